// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the session flow accumulator RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define SFA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SFA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== hw/rtl/sfa_pkg.sv =====
// Types and constants of the session flow accumulator.
// No dependencies.
package sfa_pkg;
  localparam int NODE_CAPACITY = 64;
  localparam int NODE_W        = $clog2(NODE_CAPACITY);
  localparam int USED_W        = NODE_W + 1;
  localparam int PAIR_W        = 2 * NODE_W;
  localparam int PAIR_SLOTS    = NODE_CAPACITY * NODE_CAPACITY;
  localparam int CNT_W         = 48;
  localparam int DEG_W         = 7;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [DEG_W-1:0] DEG_MAX = '1;

  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;
  localparam logic [7:0]  PROTO_ICMP = 8'd1;
  localparam logic [15:0] PORT_HTTPS = 16'd443;

  localparam logic [1:0] ST_UPDATED = 2'd0;
  localparam logic [1:0] ST_CREATED = 2'd1;
  localparam logic [1:0] ST_DROPPED = 2'd2;

  // Pair counter fields, one memory word each, visited in this order.
  typedef enum logic [3:0] {
    F_TOTB, F_TOTT, F_TCPB, F_TCPT, F_UDPB, F_UDPT, F_ICMB, F_ICMT, F_HTTPS, F_LAST
  } field_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SRC_RD, S_SRC_CMP, S_DST_RD, S_DST_CMP, S_NODE_RD,
    S_NODE_WR, S_PAIR_RD, S_PAIR_WR, S_DONE
  } state_t;
endpackage

// ===== hw/rtl/session_flow_accumulator.sv =====
// Top level of the session flow accumulator: node table, pair table, sequencer.
// Depends on sfa_pkg and assert_macros.svh.
//
// A session record runs its two key searches, then the counter read-modify-write
// through one shared 48-bit saturating adder (3 node steps, then 9 pair fields,
// each read and then written), then presents its result and waits in the result
// state until the output takes it. A search takes one key memory read and one
// compare per node entry, and one more step when the key is absent and appended.
// ready is low during that work, so no new record is taken before the last one
// is through. After reset a clearing pass sweeps all 4096 entries of the pair
// presence memory before the first record is taken.
`include "assert_macros.svh"
module session_flow_accumulator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] src_addr,
  input  logic [31:0] dst_addr,
  input  logic [7:0]  protocol,
  input  logic [15:0] dest_port,
  input  logic [31:0] byte_count,
  input  logic [31:0] session_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [5:0]  src_index,
  output logic [5:0]  dst_index,
  output logic [47:0] src_out_bytes,
  output logic [47:0] dst_in_bytes,
  output logic [6:0]  src_fanout,
  output logic [47:0] pair_bytes,
  output logic [47:0] pair_time
);
  import sfa_pkg::*;

  // memories
  logic [31:0]      key_mem  [NODE_CAPACITY];
  logic [CNT_W-1:0] in_mem   [NODE_CAPACITY];
  logic [CNT_W-1:0] out_mem  [NODE_CAPACITY];
  logic [DEG_W-1:0] deg_mem  [NODE_CAPACITY];
  logic             pres_mem [PAIR_SLOTS];
  logic [CNT_W-1:0] cnt_mem  [PAIR_SLOTS*9];

  state_t state, state_next;
  logic [USED_W-1:0] node_used;
  logic [USED_W-1:0] idx;
  logic [PAIR_W-1:0] clr_idx;
  logic [NODE_W-1:0] su, sv;
  logic [31:0] r_src, r_dst, r_bytes, r_time;
  logic [7:0]  r_proto;
  logic [15:0] r_port;
  logic [31:0] key_q;
  logic [CNT_W-1:0] in_q, out_q, cnt_q;
  logic [DEG_W-1:0] deg_q;
  logic pres_q, is_new;
  field_t fld;
  logic [1:0] nphase;
  logic [CNT_W-1:0] res_out, res_in, res_pb, res_pt;
  logic [DEG_W-1:0] res_deg;

  // shared saturating adder
  logic [CNT_W-1:0] add_a;
  logic [31:0]      add_b;
  logic [CNT_W:0]   add_sum;
  logic [CNT_W-1:0] add_y;
  assign add_sum = {1'b0, add_a} + {{(CNT_W-31){1'b0}}, add_b};
  assign add_y   = add_sum[CNT_W] ? CNT_MAX : add_sum[CNT_W-1:0];

  logic [PAIR_W-1:0] pidx;
  assign pidx = {su, sv};
  logic [PAIR_W+3:0] caddr;
  assign caddr = (PAIR_W+4)'(pidx) * (PAIR_W+4)'(9) + (PAIR_W+4)'(fld);

  logic fld_hit;
  always_comb begin
    case (fld)
      F_TOTB, F_TOTT: fld_hit = 1'b1;
      F_TCPB, F_TCPT: fld_hit = (r_proto == PROTO_TCP);
      F_UDPB, F_UDPT: fld_hit = (r_proto == PROTO_UDP);
      F_ICMB, F_ICMT: fld_hit = (r_proto == PROTO_ICMP);
      F_HTTPS:        fld_hit = (r_proto == PROTO_TCP) && (r_port == PORT_HTTPS);
      default:        fld_hit = 1'b0;
    endcase
  end
  logic fld_time;
  assign fld_time = (fld == F_TOTT) || (fld == F_TCPT) || (fld == F_UDPT) ||
                    (fld == F_ICMT);

  always_comb begin
    add_a = cnt_q;
    add_b = fld_time ? r_time : r_bytes;
    if (state == S_NODE_WR) begin
      add_a = (nphase == 2'd0) ? out_q : in_q;
      add_b = r_bytes;
    end
    if (is_new && state == S_PAIR_WR) add_a = '0;
  end

  logic full;
  assign full = (node_used == USED_W'(NODE_CAPACITY));

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:   if (clr_idx == '1) state_next = S_IDLE;
      S_IDLE:    if (in_valid) state_next = S_SRC_RD;
      S_SRC_RD:  state_next = (idx == node_used) ? (full ? S_DONE : S_DST_RD) : S_SRC_CMP;
      S_SRC_CMP: state_next = (key_q == r_src) ? S_DST_RD : S_SRC_RD;
      S_DST_RD:  state_next = (idx == node_used) ? (full ? S_DONE : S_NODE_RD)
                                                : S_DST_CMP;
      S_DST_CMP: state_next = (key_q == r_dst) ? S_NODE_RD : S_DST_RD;
      S_NODE_RD: state_next = S_NODE_WR;
      S_NODE_WR: if (nphase == 2'd2) state_next = S_PAIR_RD;
      S_PAIR_RD: state_next = S_PAIR_WR;
      S_PAIR_WR: state_next = (fld == F_HTTPS) ? S_DONE : S_PAIR_RD;
      S_DONE:    if (out_ready) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      node_used <= '0;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_idx <= clr_idx + 1'b1;
      if ((state == S_SRC_RD || state == S_DST_RD) && idx == node_used && !full)
        node_used <= node_used + 1'b1;
    end
  end

  // memory ports
  always_ff @(posedge clk) begin
    key_q <= key_mem[idx[NODE_W-1:0]];
    in_q  <= in_mem[sv];
    out_q <= out_mem[su];
    deg_q <= deg_mem[su];
    pres_q <= pres_mem[pidx];
    cnt_q <= cnt_mem[caddr];
    if (state == S_CLEAR) pres_mem[clr_idx] <= 1'b0;
    if ((state == S_SRC_RD || state == S_DST_RD) && idx == node_used && !full) begin
      key_mem[idx[NODE_W-1:0]] <= (state == S_SRC_RD) ? r_src : r_dst;
      in_mem[idx[NODE_W-1:0]]  <= '0;
      out_mem[idx[NODE_W-1:0]] <= '0;
      deg_mem[idx[NODE_W-1:0]] <= '0;
    end
    if (state == S_NODE_WR) begin
      if (nphase == 2'd0) out_mem[su] <= add_y;
      if (nphase == 2'd1) in_mem[sv] <= add_y;
      if (nphase == 2'd2 && !pres_q) begin
        pres_mem[pidx] <= 1'b1;
        if (deg_q != DEG_MAX) deg_mem[su] <= deg_q + 1'b1;
      end
    end
    if (state == S_PAIR_WR && (fld_hit || is_new))
      cnt_mem[caddr] <= fld_hit ? add_y : '0;
  end

  // sequencing registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        r_src <= src_addr; r_dst <= dst_addr; r_proto <= protocol;
        r_port <= dest_port; r_bytes <= byte_count; r_time <= session_time;
        idx <= '0;
        status <= ST_DROPPED;
        src_index <= '0; dst_index <= '0; src_out_bytes <= '0;
        dst_in_bytes <= '0; src_fanout <= '0; pair_bytes <= '0; pair_time <= '0;
      end
      S_SRC_RD: if (idx == node_used) begin
        su <= idx[NODE_W-1:0]; idx <= '0;
      end
      S_SRC_CMP: if (key_q == r_src) begin
        su <= idx[NODE_W-1:0]; idx <= '0;
      end else idx <= idx + 1'b1;
      S_DST_RD: if (idx == node_used) sv <= idx[NODE_W-1:0];
      S_DST_CMP: if (key_q == r_dst) sv <= idx[NODE_W-1:0];
                 else idx <= idx + 1'b1;
      S_NODE_RD: nphase <= 2'd0;
      S_NODE_WR: begin
        nphase <= nphase + 1'b1;
        if (nphase == 2'd0) res_out <= add_y;
        if (nphase == 2'd1) res_in <= add_y;
        if (nphase == 2'd2) begin
          is_new <= !pres_q;
          res_deg <= (!pres_q && deg_q != DEG_MAX) ? deg_q + 1'b1 : deg_q;
          fld <= F_TOTB;
        end
      end
      S_PAIR_RD: ;
      S_PAIR_WR: begin
        if (fld == F_TOTB) res_pb <= add_y;
        if (fld == F_TOTT) res_pt <= add_y;
        fld <= field_t'(fld + 1'b1);
        // load the result on the last field so it is valid with out_valid
        if (fld == F_HTTPS) begin
          status <= is_new ? ST_CREATED : ST_UPDATED;
          src_index <= 6'(su); dst_index <= 6'(sv);
          src_out_bytes <= res_out; dst_in_bytes <= res_in; src_fanout <= res_deg;
          pair_bytes <= res_pb; pair_time <= res_pt;
        end
      end
      default: ;
    endcase
  end

  `SFA_ASSERT_IMP(a_no_both, out_valid, !in_ready)
  `SFA_ASSERT_IMP(a_used_max, 1'b1, node_used <= USED_W'(NODE_CAPACITY))
  `SFA_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(status))
endmodule

// ===== test/sfa_checker.sv =====
// Checker for the session flow accumulator: watches both channels, models the node and pair tables.
// Depends on sfa_pkg.
`timescale 1ns / 1ps
module sfa_checker
  import sfa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] src_addr,
  input  logic [31:0] dst_addr,
  input  logic [7:0]  protocol,
  input  logic [15:0] dest_port,
  input  logic [31:0] byte_count,
  input  logic [31:0] session_time,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  status,
  input  logic [5:0]  src_index,
  input  logic [5:0]  dst_index,
  input  logic [47:0] src_out_bytes,
  input  logic [47:0] dst_in_bytes,
  input  logic [6:0]  src_fanout,
  input  logic [47:0] pair_bytes,
  input  logic [47:0] pair_time,
  output int          fail_count,
  output int          pending
);
  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  src_index;
    logic [5:0]  dst_index;
    logic [47:0] src_out_bytes;
    logic [47:0] dst_in_bytes;
    logic [6:0]  src_fanout;
    logic [47:0] pair_bytes;
    logic [47:0] pair_time;
  } flow_result_t;

  flow_result_t result_q[$];

  int               nodes_in_use;
  logic [31:0]      key_tab[NODE_CAPACITY];
  logic [CNT_W-1:0] in_tot[NODE_CAPACITY];
  logic [CNT_W-1:0] out_tot[NODE_CAPACITY];
  logic [DEG_W-1:0] fanout_tab[NODE_CAPACITY];
  bit               pair_seen[PAIR_SLOTS];
  logic [CNT_W-1:0] pair_byte_tot[PAIR_SLOTS];
  logic [CNT_W-1:0] pair_time_tot[PAIR_SLOTS];

  function automatic logic [CNT_W-1:0] sat_sum(logic [CNT_W-1:0] a, logic [31:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {{(CNT_W-31){1'b0}}, b};
    return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
  endfunction

  // Returns the slot of the key, appending it when absent; -1 on a full table.
  function automatic int lookup_node(logic [31:0] key);
    for (int i = 0; i < nodes_in_use; i++)
      if (key_tab[i] == key) return i;
    if (nodes_in_use >= NODE_CAPACITY) return -1;
    key_tab[nodes_in_use] = key;
    in_tot[nodes_in_use] = '0;
    out_tot[nodes_in_use] = '0;
    fanout_tab[nodes_in_use] = '0;
    nodes_in_use++;
    return nodes_in_use - 1;
  endfunction

  function automatic flow_result_t account_session(logic [31:0] sa, logic [31:0] da,
                                                   logic [31:0] nb, logic [31:0] dur);
    flow_result_t r;
    int u, v, p;
    r = '0;
    u = lookup_node(sa);
    v = lookup_node(da);
    if (u < 0 || v < 0) begin
      r.status = ST_DROPPED;
      return r;
    end
    p = u * NODE_CAPACITY + v;
    out_tot[u] = sat_sum(out_tot[u], nb);
    in_tot[v] = sat_sum(in_tot[v], nb);
    r.status = ST_UPDATED;
    if (!pair_seen[p]) begin
      pair_seen[p] = 1'b1;
      pair_byte_tot[p] = '0;
      pair_time_tot[p] = '0;
      if (fanout_tab[u] != DEG_MAX) fanout_tab[u]++;
      r.status = ST_CREATED;
    end
    // Per-protocol counters are not visible at the outputs; only totals are modeled.
    pair_byte_tot[p] = sat_sum(pair_byte_tot[p], nb);
    pair_time_tot[p] = sat_sum(pair_time_tot[p], dur);
    r.src_index = u[5:0];
    r.dst_index = v[5:0];
    r.src_out_bytes = out_tot[u];
    r.dst_in_bytes = in_tot[v];
    r.src_fanout = fanout_tab[u];
    r.pair_bytes = pair_byte_tot[p];
    r.pair_time = pair_time_tot[p];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  assign pending = result_q.size();

  initial begin
    fail_count = 0;
    nodes_in_use = 0;
    foreach (pair_seen[i]) pair_seen[i] = 1'b0;
  end

  always @(posedge clk) begin
    flow_result_t w;
    if (!rst && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        report_mismatch("unexpected transfer", 64'(status), 64'(0));
      end else begin
        w = result_q.pop_front();
        if (status !== w.status) report_mismatch("status", 64'(status), 64'(w.status));
        if (src_index !== w.src_index)
          report_mismatch("src_index", 64'(src_index), 64'(w.src_index));
        if (dst_index !== w.dst_index)
          report_mismatch("dst_index", 64'(dst_index), 64'(w.dst_index));
        if (src_out_bytes !== w.src_out_bytes)
          report_mismatch("src_out_bytes", 64'(src_out_bytes), 64'(w.src_out_bytes));
        if (dst_in_bytes !== w.dst_in_bytes)
          report_mismatch("dst_in_bytes", 64'(dst_in_bytes), 64'(w.dst_in_bytes));
        if (src_fanout !== w.src_fanout)
          report_mismatch("src_fanout", 64'(src_fanout), 64'(w.src_fanout));
        if (pair_bytes !== w.pair_bytes)
          report_mismatch("pair_bytes", 64'(pair_bytes), 64'(w.pair_bytes));
        if (pair_time !== w.pair_time)
          report_mismatch("pair_time", 64'(pair_time), 64'(w.pair_time));
      end
    end
    if (!rst && in_valid && in_ready)
      result_q.push_back(account_session(src_addr, dst_addr, byte_count, session_time));
  end
endmodule

// ===== test/tb_top.sv =====
// Top of the session flow accumulator testbench: clock, reset, stimulus, verdict.
// Depends on sfa_pkg, sfa_checker and the session_flow_accumulator RTL.
`timescale 1ns / 1ps
module tb_top;
  import sfa_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] src_addr = '0;
  logic [31:0] dst_addr = '0;
  logic [7:0]  protocol = '0;
  logic [15:0] dest_port = '0;
  logic [31:0] byte_count = '0;
  logic [31:0] session_time = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [5:0]  src_index, dst_index;
  logic [47:0] src_out_bytes, dst_in_bytes, pair_bytes, pair_time;
  logic [6:0]  src_fanout;
  int          fail_count, pending;
  bit          calm = 1'b0;
  logic [31:0] addr_pool[16];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  session_flow_accumulator u_dut (.*);
  sfa_checker u_chk (.*);

  // Random receiver stalls, until calm is set.
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 4);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Leave valid high after the transfer; the next call replaces the payload or idles.
  task automatic send_session(logic [31:0] sa, logic [31:0] da, logic [7:0] pr,
                              logic [15:0] pt, logic [31:0] nb, logic [31:0] dur);
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    src_addr <= sa;
    dst_addr <= da;
    protocol <= pr;
    dest_port <= pt;
    byte_count <= nb;
    session_time <= dur;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_proto();
    case ($urandom_range(0, 4))
      0: return PROTO_TCP;
      1: return PROTO_UDP;
      2: return PROTO_ICMP;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    logic [31:0] sa, da;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, each protocol, HTTPS, self pair, repeat pair.
    send_session(32'h0, 32'hFFFF_FFFF, PROTO_TCP, PORT_HTTPS, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_session(32'h0, 32'hFFFF_FFFF, PROTO_TCP, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_session(32'hFFFF_FFFF, 32'h0, PROTO_UDP, 16'h0, 32'h0, 32'h0);
    send_session(32'hC0A8_0001, 32'hC0A8_0001, PROTO_ICMP, 16'h0, 32'd1500, 32'h0001_8000);
    send_session(32'hC0A8_0001, 32'hC0A8_0001, 8'hFF, 16'd80, 32'd1, 32'd1);
    send_session(32'h0, 32'h0A00_0001, 8'd0, PORT_HTTPS, 32'd77, 32'd5);
    repeat (2) send_session(32'h0, 32'hFFFF_FFFF, PROTO_UDP, 16'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // Hold off until every expected result has arrived.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    foreach (addr_pool[i]) addr_pool[i] = $urandom;
    for (int k = 0; k < 750; k++) begin
      if (k == 680) calm = 1'b1;
      // Mostly reuse a small pool so pairs repeat; fresh keys slowly fill the table.
      sa = ($urandom_range(0, 9) < 8) ? addr_pool[$urandom_range(0, 15)] : $urandom;
      da = ($urandom_range(0, 9) < 8) ? addr_pool[$urandom_range(0, 15)] : $urandom;
      if ($urandom_range(0, 19) == 0) da = sa;
      send_session(sa, da, pick_proto(),
                   ($urandom_range(0, 2) == 0) ? PORT_HTTPS : 16'($urandom),
                   ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : $urandom,
                   $urandom);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("Some tests failed");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/sfa_pkg.sv
hw/rtl/session_flow_accumulator.sv
test/sfa_checker.sv
test/tb_top.sv
